### rtl/core/qfe_pkg.sv
// ----------------------------------------------------------------------------
// qfe_pkg
// Shared types and constants of the quadratic feature expander.
// ----------------------------------------------------------------------------
package qfe_pkg;

  localparam int MaxCols    = 8;
  localparam int ColW       = $clog2(MaxCols);
  localparam int LenW       = 4;
  localparam int SampleW    = 16;
  localparam int IndexW     = 6;
  localparam int ValueW     = 32;
  localparam int OutDataW   = 40;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  // configuration register indexes
  localparam logic CFG_QUAD_ENABLE = 1'b0;
  localparam logic CFG_ROW_LENGTH  = 1'b1;

  // one classified item handed from front to back
  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic [ColW-1:0]    col;
    logic               last_col;
    logic               quad;
    logic [LenW-1:0]    len;
  } qfe_cmd_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } qfe_qstat_t;

  typedef enum logic {
    S_LIN,
    S_PROD
  } qfe_state_t;

endpackage

### rtl/core/qfe_front.sv
// ----------------------------------------------------------------------------
// qfe_front
// Accepts samples, tracks the column and tags each item for the back end.
// ----------------------------------------------------------------------------
module qfe_front import qfe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [SampleW-1:0] sample,
  input  logic               quad_en,
  input  logic [LenW-1:0]    row_len,
  input  qfe_qstat_t         qstat,
  output logic               push,
  output qfe_cmd_t           push_cmd
);

  logic [ColW-1:0] col_r;
  logic [ColW-1:0] col_nxt;
  logic [LenW-1:0] len_eff;
  logic [LenW-1:0] col_inc;

  // zero reads as one, above the store depth saturates
  always_comb begin
    if (row_len == '0) begin
      len_eff = LenW'(1);
    end else if (row_len > LenW'(MaxCols)) begin
      len_eff = LenW'(MaxCols);
    end else begin
      len_eff = row_len;
    end
  end

  assign col_inc   = LenW'(col_r) + LenW'(1);
  assign in_tready = !qstat.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    push_cmd.sample   = sample;
    push_cmd.col      = col_r;
    push_cmd.last_col = (col_inc >= len_eff);
    push_cmd.quad     = quad_en;
    push_cmd.len      = len_eff;
  end

  assign col_nxt = push_cmd.last_col ? '0 : col_inc[ColW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (push) begin
      col_r <= col_nxt;
    end
  end

endmodule

### rtl/core/qfe_queue.sv
// ----------------------------------------------------------------------------
// qfe_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module qfe_queue import qfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  qfe_cmd_t   push_cmd,
  output qfe_qstat_t qstat,
  output logic       pop_valid,
  input  logic       pop,
  output qfe_cmd_t   pop_cmd
);

  qfe_cmd_t              buf_r [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_r;
  logic [QueuePtrW-1:0]  rd_ptr_r;
  logic [QueuePtrW:0]    count_r;
  logic                  do_pop;

  assign qstat.full  = (count_r == (QueuePtrW+1)'(QueueDepth));
  assign qstat.empty = (count_r == '0);
  assign pop_valid   = !qstat.empty;
  assign pop_cmd     = buf_r[rd_ptr_r];
  assign do_pop      = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QueuePtrW'(1);
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + (QueuePtrW+1)'(1);
        2'b01:   count_r <= count_r - (QueuePtrW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/core/qfe_back.sv
// ----------------------------------------------------------------------------
// qfe_back
// Row store, product sequencer, multiplier and output register.
// ----------------------------------------------------------------------------
module qfe_back import qfe_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  qfe_cmd_t          cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IndexW-1:0] out_index,
  output logic [ValueW-1:0] out_value,
  output logic              out_end
);

  qfe_state_t state_r;
  qfe_state_t state_nxt;

  logic [SampleW-1:0] row_mem [MaxCols];

  logic [ColW-1:0]   a_r;
  logic [ColW-1:0]   b_r;
  logic [LenW-1:0]   len_r;
  logic [IndexW-1:0] idx_r;

  logic adv;
  logic issue_lin;
  logic issue_prod;
  logic prod_last;
  logic b_wrap;

  // stage 1: read data and tags
  logic                      v1_r;
  logic                      lin1_r;
  logic signed [SampleW-1:0] smp1_r;
  logic signed [SampleW-1:0] rd_a_r;
  logic signed [SampleW-1:0] rd_b_r;
  logic [IndexW-1:0]         idx1_r;
  logic                      end1_r;
  logic signed [ValueW-1:0]  prod;
  logic signed [ValueW-1:0]  lin_val;

  // stage 2: output register
  logic              out_valid_r;
  logic [IndexW-1:0] out_index_r;
  logic [ValueW-1:0] out_value_r;
  logic              out_end_r;

  assign adv       = !out_valid_r || out_ready;
  assign b_wrap    = (LenW'(b_r) + LenW'(1) == len_r);
  assign prod_last = (LenW'(a_r) + LenW'(1) == len_r) && b_wrap;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LIN: begin
        if (adv && cmd_valid && cmd.last_col && cmd.quad) begin
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        if (adv && prod_last) begin
          state_nxt = S_LIN;
        end
      end
      default: state_nxt = S_LIN;
    endcase
  end

  always_comb begin
    cmd_ready  = 1'b0;
    issue_prod = 1'b0;
    unique case (state_r)
      S_LIN:   cmd_ready  = adv;
      S_PROD:  issue_prod = adv;
      default: cmd_ready  = 1'b0;
    endcase
  end

  assign issue_lin = cmd_ready && cmd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LIN;
      idx_r   <= IndexW'(1);
    end else begin
      state_r <= state_nxt;
      if (issue_lin) begin
        idx_r <= (cmd.last_col && !cmd.quad) ? IndexW'(1) : idx_r + IndexW'(1);
      end else if (issue_prod) begin
        idx_r <= prod_last ? IndexW'(1) : idx_r + IndexW'(1);
      end
    end
  end

  // upper-triangle walk: outer a, inner b from a to len-1
  always_ff @(posedge clk) begin
    if (issue_lin) begin
      a_r   <= '0;
      b_r   <= '0;
      len_r <= cmd.len;
    end else if (issue_prod) begin
      if (b_wrap) begin
        a_r <= a_r + ColW'(1);
        b_r <= a_r + ColW'(1);
      end else begin
        b_r <= b_r + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_lin) begin
      row_mem[cmd.col] <= cmd.sample;
    end
    if (adv) begin
      rd_a_r <= row_mem[a_r];
      rd_b_r <= row_mem[b_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= issue_lin || issue_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lin1_r <= issue_lin;
      smp1_r <= cmd.sample;
      idx1_r <= idx_r;
      end1_r <= issue_lin ? (cmd.last_col && !cmd.quad) : prod_last;
    end
  end

  assign prod    = rd_a_r * rd_b_r;
  assign lin_val = {smp1_r[SampleW-1], smp1_r, 15'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index_r <= idx1_r;
      out_value_r <= lin1_r ? lin_val : prod;
      out_end_r   <= end1_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_end   = out_end_r;

endmodule

### rtl/core/quadratic_feature_expander.sv
// ----------------------------------------------------------------------------
// quadratic_feature_expander
// Degree-2 polynomial feature expansion of rows of Q1.15 samples into Q2.30.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+---------------------------------
//  in_     | in  | in_tvalid / in_tready      | tdata[15:0] sample
//  out_    | out | out_tvalid / out_tready    | tdata[5:0] index, [37:6] value,
//          |     |                            | tlast row end
//  cfg_    | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data[3:0]
//
//  Each item's linear feature passes through the stage 1 registers and then
//  the output register. On the last column with quad_enable set,
//  len*(len+1)/2 product features follow, one per cycle unless out_tready
//  stalls, paced by the single 16x16 multiplier stage (36 products for an
//  8-column row, 44 features with its linear features).
//  Reset is synchronous; the row store needs no clearing pass.
//  An out_tready stall freezes the back end; the 4-entry queue keeps the
//  input side open until it fills.
// ----------------------------------------------------------------------------
module quadratic_feature_expander import qfe_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // sample item: [15:0] sample
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SampleW-1:0]  in_tdata,
  // feature item: [5:0] feature_index, [37:6] feature_value, [39:38] zero
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tlast,
  // register writes: index 0 quad_enable, index 1 row_length
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [LenW-1:0]     cfg_data
);

  logic            quad_en_r;
  logic [LenW-1:0] row_len_r;

  qfe_qstat_t qstat;
  logic       push;
  qfe_cmd_t   push_cmd;
  logic       q_valid;
  logic       q_pop;
  qfe_cmd_t   q_cmd;

  logic [IndexW-1:0] feat_index;
  logic [ValueW-1:0] feat_value;

  // registers are writable any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_en_r <= 1'b0;
      row_len_r <= LenW'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUAD_ENABLE: quad_en_r <= cfg_data[0];
        CFG_ROW_LENGTH:  row_len_r <= cfg_data;
        default:         quad_en_r <= quad_en_r;
      endcase
    end
  end

  qfe_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sample   (in_tdata),
    .quad_en  (quad_en_r),
    .row_len  (row_len_r),
    .qstat    (qstat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  qfe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .qstat    (qstat),
    .pop_valid(q_valid),
    .pop      (q_pop),
    .pop_cmd  (q_cmd)
  );

  qfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(q_valid),
    .cmd_ready(q_pop),
    .cmd      (q_cmd),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_index(feat_index),
    .out_value(feat_value),
    .out_end  (out_tlast)
  );

  assign out_tdata = {2'b00, feat_value, feat_index};

endmodule

### rtl/core/qfe_checker.sv
// ----------------------------------------------------------------------------
// qfe_checker
// Port-level checks of feature numbering and output stalls.
// ----------------------------------------------------------------------------
module qfe_checker import qfe_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tlast
);

  logic              row_start_r;
  logic [IndexW-1:0] prev_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_start_r <= 1'b1;
      prev_idx_r  <= '0;
    end else if (out_tvalid && out_tready) begin
      row_start_r <= out_tlast;
      prev_idx_r  <= out_tdata[IndexW-1:0];
    end
  end

  // first feature of a row is number one
  a_row_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && row_start_r |-> out_tdata[IndexW-1:0] == IndexW'(1))
    else $error("row does not start at feature one");

  // numbering steps by one inside a row
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !row_start_r |-> out_tdata[IndexW-1:0] == prev_idx_r + IndexW'(1))
    else $error("feature index skipped or repeated");

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed under stall");

endmodule

bind quadratic_feature_expander qfe_checker u_qfe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

### dv/quadratic_feature_expander_tb.sv
// ----------------------------------------------------------------------------
// quadratic_feature_expander_tb
// Self-checking bench for the degree-2 polynomial feature expander.
// Samples go in on the in_ stream and the bench keeps its own running copy of
// the row store, column count and feature index. From that copy it works out
// every linear and product feature each sample should produce. Each feature
// item on the out_ stream is checked field by field against the oldest
// outstanding prediction. Directed rows hit the sample extremes, the length
// clamps and mid-row register changes. Random rows then run under three
// sender/receiver idle mixes, after one long receiver hold-off.
// ----------------------------------------------------------------------------
module quadratic_feature_expander_tb;
  import qfe_pkg::*;

  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off
  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 8;     // margin past the pipe and queue drain

  // one predicted feature item
  typedef struct packed {
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;
    logic              row_end;
  } feature_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [SampleW-1:0]  in_tdata;    // [15:0] sample
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;   // [5:0] index, [37:6] value, [39:38] zero
  logic                out_tlast;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic [LenW-1:0]     cfg_data;

  // bench copy of the block's registers and row state
  logic                model_quad;
  logic [LenW-1:0]     model_len;
  logic [SampleW-1:0]  row_samples [MaxCols];
  logic [ColW-1:0]     col_pos;
  logic [IndexW-1:0]   feat_idx;

  feature_t expected_features [$];

  int  errors = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 20;
  int  recv_idle_pct = 62;
  bit  hold_req = 1'b0;   // toggled by test_backpressure_fill
  bit  hold_seen = 1'b0;  // follows hold_req, owned by the ready driver

  quadratic_feature_expander uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Feature prediction
  // --------------------------------------------------------------------------
  function automatic void push_feature(input int value, input bit row_end);
    expected_features.push_back('{index: feat_idx, value: ValueW'(value),
                                  row_end: row_end});
    feat_idx = feat_idx + IndexW'(1);  // wraps at 64
  endfunction

  // One sample: its linear feature, then on the final column the upper
  // triangle of products over columns 0..len-1 when quad mode is on.
  function automatic void expand_sample(input logic [SampleW-1:0] s);
    int len;
    int col;
    bit last_col;
    if (model_len == 0) len = 1;
    else if (model_len > MaxCols) len = MaxCols;
    else len = int'(model_len);
    col = int'(col_pos);
    // a row length lowered mid-row makes the current column the final one
    last_col = (col + 1 >= len);
    row_samples[col] = s;
    // Q1.15 into Q2.30 is a shift by 15
    push_feature(int'($signed(s)) * 32768, last_col && !model_quad);
    if (!last_col) begin
      col_pos = ColW'(col + 1);
      return;
    end
    if (model_quad) begin
      for (int a = 0; a < len; a++) begin
        for (int b = a; b < len; b++) begin
          push_feature(int'($signed(row_samples[a])) * int'($signed(row_samples[b])),
                       (a == len - 1) && (b == len - 1));
        end
      end
    end
    col_pos = '0;
    feat_idx = IndexW'(1);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: ready generation and checking
  // --------------------------------------------------------------------------
  // Random back-pressure, plus a counted hold-off whenever hold_req toggles.
  initial begin : ready_driver
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [ValueW-1:0] want,
                                 input logic [ValueW-1:0] got);
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    errors++;
  endtask

  always @(posedge clk) begin : feature_check
    feature_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_features.size() == 0) begin
        $display("%0t: unexpected feature item: expected none, got tdata %h tlast %b",
                 $time, out_tdata, out_tlast);
        errors++;
      end else begin
        want = expected_features.pop_front();
        if (out_tdata[IndexW-1:0] !== want.index)
          report_mismatch("feature_index", ValueW'(want.index),
                          ValueW'(out_tdata[IndexW-1:0]));
        if (out_tdata[IndexW +: ValueW] !== want.value)
          report_mismatch("feature_value", want.value, out_tdata[IndexW +: ValueW]);
        if (out_tlast !== want.row_end)
          report_mismatch("row_end", ValueW'(want.row_end), ValueW'(out_tlast));
        if (out_tdata[OutDataW-1:IndexW+ValueW] !== '0)
          report_mismatch("tdata pad", '0, ValueW'(out_tdata[OutDataW-1:IndexW+ValueW]));
      end
    end
  end

  // Any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d features outstanding",
               $time, STALL_LIMIT, expected_features.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Prediction happens when the item is first offered; it is held until taken.
  task automatic send_sample(input logic [SampleW-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    expand_sample(s);
    do @(posedge clk); while (!in_tready);
  endtask

  // Stop sending and wait until every predicted feature has come out.
  task automatic drain_features();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_features.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_reg(input logic idx, input logic [LenW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_QUAD_ENABLE) model_quad = data[0];
    else model_len = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SampleW-1:0] random_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SampleW'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset values: linear only, one column, so every sample ends its row.
  task automatic test_reset_defaults();
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    drain_features();
  endtask

  // Full 8-column quad row through a saturated length, with the sample
  // extremes and alternating bit patterns; (-1.0)^2 gives the top value.
  task automatic test_quad_extremes();
    logic [SampleW-1:0] pats [8];
    pats = '{16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
             16'h0000, 16'h5555, 16'hAAAA, 16'h8000};
    write_reg(CFG_QUAD_ENABLE, LenW'(1));
    write_reg(CFG_ROW_LENGTH, LenW'(15));
    foreach (pats[i]) send_sample(pats[i]);
    drain_features();
  endtask

  // Length zero acts as one column: linear feature plus its square.
  task automatic test_zero_length();
    write_reg(CFG_ROW_LENGTH, LenW'(0));
    send_sample(16'h8000);
    drain_features();
  endtask

  // Length cut from 6 to 2 after three columns: the fourth sample closes the
  // row and the products only cover the first two columns.
  task automatic test_row_length_cut();
    write_reg(CFG_ROW_LENGTH, LenW'(6));
    send_sample(16'h1234);
    send_sample(16'hC000);
    send_sample(16'h7FFF);
    drain_features();
    write_reg(CFG_ROW_LENGTH, LenW'(2));
    send_sample(16'h4000);
    drain_features();
  endtask

  // Quad mode switched on partway through a 3-column row; the index keeps
  // counting across the change.
  task automatic test_quad_toggle_mid_row();
    write_reg(CFG_QUAD_ENABLE, LenW'(0));
    write_reg(CFG_ROW_LENGTH, LenW'(3));
    send_sample(16'hFFFE);
    drain_features();
    write_reg(CFG_QUAD_ENABLE, LenW'(1));
    send_sample(16'h0003);
    send_sample(16'h8001);
    drain_features();
  endtask

  // Receiver holds off while two full 8-column rows are offered, so the
  // internal queue fills and in_tready drops; then a full drain.
  task automatic test_backpressure_fill();
    write_reg(CFG_QUAD_ENABLE, LenW'(1));
    write_reg(CFG_ROW_LENGTH, LenW'(MaxCols));
    hold_req = ~hold_req;
    repeat (2 * MaxCols) send_sample(random_sample());
    drain_features();
  endtask

  // Mostly whole rows under random settings (small lengths favored), some
  // rows cut short so the next setting lands mid-row.
  task automatic test_random_rows(input int n_items, input int tx_idle, input int rx_idle);
    int sent;
    int eff;
    int cols;
    int pick;
    logic [LenW-1:0] len;
    sent = 0;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 8) len = '0;
      else if (pick < 18) len = LenW'($urandom_range(15, MaxCols + 1));
      else if (pick < 35) len = LenW'(MaxCols);
      else len = LenW'($urandom_range(4, 1));
      write_reg(CFG_QUAD_ENABLE, LenW'($urandom_range(1)));
      write_reg(CFG_ROW_LENGTH, len);
      if (len == 0) eff = 1;
      else if (len > MaxCols) eff = MaxCols;
      else eff = int'(len);
      repeat ($urandom_range(3, 1)) begin
        cols = eff;
        if ($urandom_range(5) == 0) cols = $urandom_range(eff, 1);
        repeat (cols) begin
          send_sample(random_sample());
          sent++;
        end
      end
      drain_features();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_QUAD_ENABLE;
    cfg_data   = '0;
    model_quad = 1'b0;
    model_len  = LenW'(1);
    col_pos    = '0;
    feat_idx   = IndexW'(1);
    foreach (row_samples[i]) row_samples[i] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_quad_extremes();
    test_zero_length();
    test_row_length_cut();
    test_quad_toggle_mid_row();
    test_backpressure_fill();
    test_random_rows(22, 20, 62);
    test_random_rows(22, 62, 20);
    test_random_rows(22, 0, 0);
    drain_features();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### quadratic_feature_expander.f
rtl/core/qfe_pkg.sv
rtl/core/qfe_front.sv
rtl/core/qfe_queue.sv
rtl/core/qfe_back.sv
rtl/core/quadratic_feature_expander.sv
rtl/core/qfe_checker.sv
dv/quadratic_feature_expander_tb.sv
